>>> hw/rtl/fnst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fnst_pkg
// Shared types and constants of the noise gate and silence trim unit.
// ---------------------------------------------------------------------------
package fnst_pkg;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_ADDR_W-1:0] CSR_GATE_THR    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SILENCE_THR = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTACK      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD        = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_PREROLL     = 3'd5;

   localparam logic [14:0] GATE_THR_RESET    = 15'd492;
   localparam logic [14:0] SILENCE_THR_RESET = 15'd655;
   localparam logic [16:0] ATTACK_RESET      = 17'd6554;
   localparam logic [16:0] RELEASE_RESET     = 17'd131;
   localparam logic [7:0]  HOLD_RESET        = 8'd30;
   localparam logic [7:0]  PREROLL_RESET     = 8'd10;

   localparam logic [16:0] GAIN_ONE = 17'd65536;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic KIND_LENGTH = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic load;
      logic rd_req;
      logic rd_put;
      logic proc_init;
      logic frame_set;
      logic use_sil;
      logic sweep_start;
      logic sweep_gain;
      logic gain_update;
      logic frame_adv;
      logic fwd_init;
      logic set_start;
      logic bwd_init;
      logic run_update;
      logic bwd_step;
      logic finish;
      logic put_report;
   } fnst_cmd_type;

   typedef struct packed {
      logic sweep_busy;
      logic fwd_more;
      logic bwd_more;
      logic short_utt;
      logic loud;
      logic cut;
      logic rsp_free;
   } fnst_status_type;

endpackage

>>> hw/rtl/frame_noise_gate_silence_trim_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_noise_gate_silence_trim_unit
// Frame energy noise gate with silence trim over a stored utterance.
// ---------------------------------------------------------------------------
// Load beats are accepted one per cycle while the unit is idle. A read beat
// is accepted only in idle; its result enters the response register once
// that is free. After the last load, the gate pass sweeps each frame twice
// through the single store read port (energy, then gain) and the start and
// tail passes once each. Reset is synchronous and clears control state and
// restores register defaults; the store contents stay undefined until loaded.
module frame_noise_gate_silence_trim_unit #(
   parameter int FRAME_LEN   = 160,
   parameter int MAX_SAMPLES = 65536
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fnst_pkg::REQ_TDATA_W-1:0] req_tdata,  // sample, index
   input  logic                             req_tuser,  // command
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fnst_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // trimmed_length, data,
                                                        // out_of_range, zero pad
   output logic                             rsp_tuser,  // kind
   input  logic                             csr_we,
   input  logic [fnst_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [fnst_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fnst_pkg::*;

   fnst_cmd_type    cmd;
   fnst_status_type status;

   fnst_datapath #(.FRAME_LEN(FRAME_LEN), .MAX_SAMPLES(MAX_SAMPLES)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   fnst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_LOAD) && !req_tlast && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("plain load produced a result beat");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> (rsp_tdata[32:17] == 16'd0))
      else $error("out of range read carries data");

   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_LENGTH)
      |-> (rsp_tdata[33] == 1'b0) && (rsp_tdata[32:17] == 16'd0))
      else $error("length report carries read fields");

endmodule

>>> hw/rtl/fnst_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fnst_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module fnst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/fnst_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fnst_datapath
// Sample store, frame energy and gain sweeps, trim bounds and result register.
// ---------------------------------------------------------------------------
module fnst_datapath #(
   parameter int FRAME_LEN   = 160,
   parameter int MAX_SAMPLES = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fnst_pkg::fnst_cmd_type              cmd,
   output fnst_pkg::fnst_status_type           status,
   input  logic [fnst_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                csr_we,
   input  logic [fnst_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [fnst_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fnst_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser
);
   import fnst_pkg::*;

   localparam int AW  = $clog2(MAX_SAMPLES);
   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int NW  = $clog2(FRAME_LEN + 1);
   localparam int XW  = CW + 8 + NW;
   localparam int EW  = 31 + NW;
   localparam logic [XW-1:0] FRAME_X = XW'(FRAME_LEN);
   localparam logic [CW-1:0] FRAME_C = CW'(FRAME_LEN);
   localparam logic [NW-1:0] FRAME_N = NW'(FRAME_LEN);
   localparam logic [CW-1:0] MAX_C   = CW'(MAX_SAMPLES);

   logic [14:0]  gate_thr_ff, sil_thr_ff;
   logic [16:0]  attack_ff, release_ff;
   logic [7:0]   hold_ff, preroll_ff;
   logic [29:0]  gate_sq_ff, sil_sq_ff;
   logic [XW-1:0] back_ff, hold_len_ff;

   logic [CW-1:0] loaded_ff, total_ff, pos_ff, start_ff, end_ff, trim_ff, kept_ff;
   logic [NW-1:0] n_ff, k_ff;
   logic          thr_sel_ff, active_ff, gmode_ff, v1_ff, v2_ff;
   logic [AW-1:0] a1_ff, a2_ff;
   logic signed [33:0] prod_ff;
   logic [EW-1:0] acc_ff, bound_ff;
   logic [16:0]   gain_ff;
   logic [8:0]    run_ff;
   logic          oor_ff;
   logic          rsp_valid_ff, rsp_kind_ff, rsp_oor_ff;
   logic [16:0]   rsp_len_ff;
   logic [15:0]   rsp_data_ff;

   logic [15:0]   idx;
   logic [XW-1:0] rd_sum, end_sum;
   logic          in_range, quiet;
   logic [CW-1:0] sweep_addr, rem, start_in, end_in;
   logic [NW-1:0] n_in;
   logic [16:0]   gain_in;
   logic [17:0]   gain_sum;
   logic [8:0]    run_in;
   logic [29:0]   sq_sel;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [15:0]   ram_wdata, ram_rdata;
   logic signed [17:0] mul_b;
   logic signed [33:0] prod_in, rnd;

   fnst_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign idx        = req_tdata[31:16];
   assign rd_sum     = XW'(trim_ff) + XW'(idx);
   assign in_range   = XW'(idx) < XW'(kept_ff);
   assign sweep_addr = pos_ff + CW'(k_ff);
   assign rnd        = prod_ff + 34'sd32768;

   assign ram_we    = (cmd.load && (loaded_ff < MAX_C)) || (v2_ff && gmode_ff);
   assign ram_waddr = cmd.load ? loaded_ff[AW-1:0] : a2_ff;
   assign ram_wdata = cmd.load ? req_tdata[15:0] : rnd[31:16];
   assign ram_re    = cmd.rd_req || active_ff;
   assign ram_raddr = cmd.rd_req ? rd_sum[AW-1:0] : sweep_addr[AW-1:0];

   assign mul_b   = gmode_ff ? $signed({1'b0, gain_ff})
                             : 18'($signed(ram_rdata));
   assign prod_in = 34'($signed(ram_rdata)) * 34'(mul_b);

   assign sq_sel = thr_sel_ff ? sil_sq_ff : gate_sq_ff;
   assign quiet  = acc_ff < bound_ff;

   assign gain_sum = {1'b0, gain_ff} + {1'b0, attack_ff};
   always_comb begin
      if (quiet) begin
         gain_in = (gain_ff > release_ff) ? gain_ff - release_ff : '0;
      end else begin
         gain_in = (gain_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE : gain_sum[16:0];
      end
   end

   assign rem  = total_ff - pos_ff;
   assign n_in = (rem < FRAME_C) ? NW'(rem) : FRAME_N;

   assign run_in   = quiet ? run_ff + 9'd1 : '0;
   assign end_sum  = XW'(pos_ff) + hold_len_ff;
   assign end_in   = (end_sum < XW'(total_ff)) ? CW'(end_sum) : total_ff;
   assign start_in = (XW'(pos_ff) > back_ff) ? CW'(XW'(pos_ff) - back_ff) : '0;

   always_comb begin
      status.sweep_busy = active_ff || v1_ff || v2_ff;
      status.fwd_more   = (XW'(pos_ff) + FRAME_X) < XW'(total_ff);
      status.bwd_more   = pos_ff >= FRAME_C;
      status.short_utt  = total_ff <= FRAME_C;
      status.loud       = acc_ff > bound_ff;
      status.cut        = run_in > {1'b0, hold_ff};
      status.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      gate_sq_ff  <= 30'(gate_thr_ff) * 30'(gate_thr_ff);
      sil_sq_ff   <= 30'(sil_thr_ff) * 30'(sil_thr_ff);
      back_ff     <= XW'(preroll_ff) * FRAME_X;
      hold_len_ff <= XW'(hold_ff) * FRAME_X;
      bound_ff    <= EW'(sq_sel) * EW'(n_ff);
      prod_ff     <= prod_in;
      a1_ff       <= ram_raddr;
      a2_ff       <= a1_ff;

      if (cmd.rd_req) begin
         oor_ff <= !in_range;
      end
      if (cmd.proc_init) begin
         total_ff <= loaded_ff;
         pos_ff   <= '0;
         start_ff <= '0;
         end_ff   <= loaded_ff;
      end
      if (cmd.frame_set) begin
         n_ff       <= n_in;
         thr_sel_ff <= cmd.use_sil;
      end
      if (cmd.frame_adv) begin
         pos_ff <= pos_ff + FRAME_C;
      end
      if (cmd.fwd_init) begin
         pos_ff <= '0;
      end
      if (cmd.set_start) begin
         start_ff <= start_in;
      end
      if (cmd.bwd_init) begin
         pos_ff     <= total_ff - FRAME_C;
         n_ff       <= FRAME_N;
         thr_sel_ff <= 1'b1;
         run_ff     <= '0;
      end
      if (cmd.run_update) begin
         run_ff <= run_in;
         if (status.cut) begin
            end_ff <= end_in;
         end
      end
      if (cmd.bwd_step) begin
         pos_ff <= pos_ff - FRAME_C;
      end
      if (cmd.sweep_start) begin
         k_ff     <= '0;
         gmode_ff <= cmd.sweep_gain;
         acc_ff   <= '0;
      end else begin
         if (active_ff) begin
            k_ff <= k_ff + 1'b1;
         end
         if (v2_ff && !gmode_ff) begin
            acc_ff <= acc_ff + EW'(prod_ff[30:0]);
         end
      end
      if (cmd.rd_put) begin
         rsp_kind_ff <= KIND_READ;
         rsp_len_ff  <= 17'(kept_ff);
         rsp_data_ff <= oor_ff ? '0 : ram_rdata;
         rsp_oor_ff  <= oor_ff;
      end
      if (cmd.put_report) begin
         rsp_kind_ff <= KIND_LENGTH;
         rsp_len_ff  <= 17'(kept_ff);
         rsp_data_ff <= '0;
         rsp_oor_ff  <= 1'b0;
      end

      if (reset) begin
         gate_thr_ff  <= GATE_THR_RESET;
         sil_thr_ff   <= SILENCE_THR_RESET;
         attack_ff    <= ATTACK_RESET;
         release_ff   <= RELEASE_RESET;
         hold_ff      <= HOLD_RESET;
         preroll_ff   <= PREROLL_RESET;
         loaded_ff    <= '0;
         gain_ff      <= GAIN_ONE;
         trim_ff      <= '0;
         kept_ff      <= '0;
         active_ff    <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_GATE_THR:    gate_thr_ff <= csr_wdata[14:0];
               CSR_SILENCE_THR: sil_thr_ff  <= csr_wdata[14:0];
               CSR_ATTACK:      attack_ff   <= csr_wdata;
               CSR_RELEASE:     release_ff  <= csr_wdata;
               CSR_HOLD:        hold_ff     <= csr_wdata[7:0];
               CSR_PREROLL:     preroll_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (cmd.load && (loaded_ff < MAX_C)) begin
            loaded_ff <= loaded_ff + 1'b1;
         end
         if (cmd.proc_init) begin
            loaded_ff <= '0;
            gain_ff   <= GAIN_ONE;
         end
         if (cmd.gain_update) begin
            gain_ff <= gain_in;
         end
         if (cmd.finish) begin
            if (start_ff >= end_ff) begin
               trim_ff <= '0;
               kept_ff <= '0;
            end else begin
               trim_ff <= start_ff;
               kept_ff <= end_ff - start_ff;
            end
         end
         if (cmd.sweep_start) begin
            active_ff <= 1'b1;
         end else if (active_ff && (k_ff == n_ff - 1'b1)) begin
            active_ff <= 1'b0;
         end
         v1_ff <= active_ff;
         v2_ff <= v1_ff;
         if (cmd.rd_put || cmd.put_report) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {6'd0, rsp_oor_ff, rsp_data_ff, rsp_len_ff};

endmodule

>>> hw/rtl/fnst_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fnst_ctrl
// Sequencer for loads, reads and the gate, start and tail passes.
// ---------------------------------------------------------------------------
module fnst_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tuser,
   input  logic                      req_tlast,
   output logic                      req_tready,
   input  fnst_pkg::fnst_status_type status,
   output fnst_pkg::fnst_cmd_type    cmd
);
   import fnst_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_PUT, ST_P_INIT, ST_P_CHK,
      ST_G_SET, ST_G_SWEEP, ST_G_WAIT, ST_G_UPD, ST_G_APPLY, ST_G_AWAIT, ST_G_NEXT,
      ST_S_SET, ST_S_SWEEP, ST_S_WAIT, ST_S_CHK,
      ST_B_INIT, ST_B_SWEEP, ST_B_WAIT, ST_B_CHK,
      ST_FIN, ST_REPORT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == CMD_READ) begin
                  cmd.rd_req = 1'b1;
                  state_in   = ST_RD_PUT;
               end else begin
                  cmd.load = 1'b1;
                  if (req_tlast) begin
                     state_in = ST_P_INIT;
                  end
               end
            end
         end
         ST_RD_PUT: begin
            if (status.rsp_free) begin
               cmd.rd_put = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_P_INIT: begin
            cmd.proc_init = 1'b1;
            state_in      = ST_P_CHK;
         end
         ST_P_CHK: begin
            state_in = status.short_utt ? ST_FIN : ST_G_SET;
         end
         ST_G_SET: begin
            cmd.frame_set = 1'b1;
            state_in      = ST_G_SWEEP;
         end
         ST_G_SWEEP: begin
            cmd.sweep_start = 1'b1;
            state_in        = ST_G_WAIT;
         end
         ST_G_WAIT: begin
            if (!status.sweep_busy) begin
               state_in = ST_G_UPD;
            end
         end
         ST_G_UPD: begin
            cmd.gain_update = 1'b1;
            state_in        = ST_G_APPLY;
         end
         ST_G_APPLY: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_gain  = 1'b1;
            state_in        = ST_G_AWAIT;
         end
         ST_G_AWAIT: begin
            if (!status.sweep_busy) begin
               state_in = ST_G_NEXT;
            end
         end
         ST_G_NEXT: begin
            if (status.fwd_more) begin
               cmd.frame_adv = 1'b1;
               state_in      = ST_G_SET;
            end else begin
               cmd.fwd_init = 1'b1;
               state_in     = ST_S_SET;
            end
         end
         ST_S_SET: begin
            cmd.frame_set = 1'b1;
            cmd.use_sil   = 1'b1;
            state_in      = ST_S_SWEEP;
         end
         ST_S_SWEEP: begin
            cmd.sweep_start = 1'b1;
            state_in        = ST_S_WAIT;
         end
         ST_S_WAIT: begin
            if (!status.sweep_busy) begin
               state_in = ST_S_CHK;
            end
         end
         ST_S_CHK: begin
            if (status.loud) begin
               cmd.set_start = 1'b1;
               state_in      = ST_B_INIT;
            end else if (status.fwd_more) begin
               cmd.frame_adv = 1'b1;
               state_in      = ST_S_SET;
            end else begin
               state_in = ST_B_INIT;
            end
         end
         ST_B_INIT: begin
            cmd.bwd_init = 1'b1;
            state_in     = ST_B_SWEEP;
         end
         ST_B_SWEEP: begin
            cmd.sweep_start = 1'b1;
            state_in        = ST_B_WAIT;
         end
         ST_B_WAIT: begin
            if (!status.sweep_busy) begin
               state_in = ST_B_CHK;
            end
         end
         ST_B_CHK: begin
            cmd.run_update = 1'b1;
            if (status.cut || !status.bwd_more) begin
               state_in = ST_FIN;
            end else begin
               cmd.bwd_step = 1'b1;
               state_in     = ST_B_SWEEP;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_REPORT;
         end
         ST_REPORT: begin
            if (status.rsp_free) begin
               cmd.put_report = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> test/frame_noise_gate_silence_trim_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_noise_gate_silence_trim_unit_test
// Self-checking bench for the noise gate and silence trim unit.
// ---------------------------------------------------------------------------
// Utterances are streamed in as load beats, mixed with read beats, under
// changing register settings and idle patterns. A predictor in the bench
// gates and trims each utterance and queues the expected length reports and
// read data, and every response beat is checked against the oldest entry.
// ---------------------------------------------------------------------------
module frame_noise_gate_silence_trim_unit_test;
   import fnst_pkg::*;

   localparam int FRAME = 160;
   localparam int DEPTH = 65536;

   typedef struct {
      logic        kind;
      logic [16:0] length;
      logic [15:0] data;
      logic        oor;
   } trim_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = CMD_LOAD;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state.
   logic signed [15:0] pcm_store [DEPTH];
   int unsigned loaded_cnt, cut_start, cut_length;
   int unsigned gate_thr, silence_thr, attack, release_step, hold, preroll;

   trim_result_type trim_expected [$];
   int mismatch_count = 0;
   int item_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;

   frame_noise_gate_silence_trim_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #60000000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint unsigned frame_power(int unsigned pos, int unsigned n);
      longint unsigned acc;
      longint v;
      acc = 0;
      for (int unsigned k = 0; k < n; k++) begin
         v = pcm_store[pos + k];
         acc += v * v;
      end
      return acc;
   endfunction

   function automatic longint unsigned power_limit(int unsigned thr, int unsigned n);
      return longint'(thr) * longint'(thr) * longint'(n);
   endfunction

   function automatic void gate_and_trim();
      int unsigned total, start_pos, stop_pos, n, run, gain;
      longint p, v, e;
      total = loaded_cnt;
      start_pos = 0;
      stop_pos = total;
      gain = 65536;
      if (total <= FRAME) begin
         cut_start = 0;
         cut_length = total;
         return;
      end
      for (int unsigned i = 0; i < total; i += FRAME) begin
         n = (total - i < FRAME) ? total - i : FRAME;
         if (frame_power(i, n) < power_limit(gate_thr, n))
            gain = (gain > release_step) ? gain - release_step : 0;
         else
            gain = (gain + attack > 65536) ? 65536 : gain + attack;
         for (int unsigned k = 0; k < n; k++) begin
            v = longint'(pcm_store[i + k]) * longint'(gain) + 32768;
            pcm_store[i + k] = 16'(v >>> 16);
         end
      end
      for (int unsigned i = 0; i < total; i += FRAME) begin
         n = (total - i < FRAME) ? total - i : FRAME;
         if (frame_power(i, n) > power_limit(silence_thr, n)) begin
            start_pos = (i > FRAME * preroll) ? i - FRAME * preroll : 0;
            break;
         end
      end
      run = 0;
      for (p = longint'(total) - FRAME; p >= 0; p -= FRAME) begin
         if (frame_power(int'(p), FRAME) < power_limit(silence_thr, FRAME))
            run++;
         else
            run = 0;
         if (run > hold) begin
            e = p + FRAME * hold;
            stop_pos = (e < total) ? int'(e) : total;
            break;
         end
      end
      if (start_pos >= stop_pos) begin
         cut_start = 0;
         cut_length = 0;
      end else begin
         cut_start = start_pos;
         cut_length = stop_pos - start_pos;
      end
   endfunction

   function automatic void predict_beat(logic cmd, logic [15:0] smp, logic lst,
                                        logic [15:0] idx);
      trim_result_type r;
      r.length = 17'(cut_length);
      r.data = '0;
      r.oor = 1'b0;
      if (cmd == CMD_LOAD) begin
         if (loaded_cnt < DEPTH) begin
            pcm_store[loaded_cnt] = smp;
            loaded_cnt++;
         end
         if (!lst)
            return;
         gate_and_trim();
         loaded_cnt = 0;
         r.kind = KIND_LENGTH;
         r.length = 17'(cut_length);
      end else begin
         r.kind = KIND_READ;
         if (idx < cut_length)
            r.data = pcm_store[cut_start + idx];
         else
            r.oor = 1'b1;
      end
      trim_expected.push_back(r);
   endfunction

   // Response checker.
   initial begin
      trim_result_type want;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (trim_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected response beat: kind %0d tdata %h",
                           rsp_tuser, rsp_tdata);
            end else begin
               want = trim_expected.pop_front();
               if (rsp_tuser !== want.kind || rsp_tdata[16:0] !== want.length ||
                   rsp_tdata[32:17] !== want.data || rsp_tdata[33] !== want.oor ||
                   rsp_tdata[39:34] !== 6'd0) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"Mismatch: expected kind %0d len %0d data %0d oor %0d,",
                               " got kind %0d len %0d data %0d oor %0d"},
                              want.kind, want.length, $signed(want.data), want.oor,
                              rsp_tuser, rsp_tdata[16:0], $signed(rsp_tdata[32:17]),
                              rsp_tdata[33]);
               end
            end
         end
      end
   end

   // Receiver stalls, random and forced.
   initial begin
      int hold_cnt;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_cnt = hold_request;
            hold_request = 0;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic send_beat(logic cmd, logic [15:0] smp, logic lst, logic [15:0] idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tlast <= lst;
      req_tdata <= {idx, smp};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_beat(cmd, smp, lst, idx);
      item_count++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (trim_expected.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, int unsigned value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      case (addr)
         CSR_GATE_THR:    gate_thr = value & 32'h7FFF;
         CSR_SILENCE_THR: silence_thr = value & 32'h7FFF;
         CSR_ATTACK:      attack = value & 32'h1FFFF;
         CSR_RELEASE:     release_step = value & 32'h1FFFF;
         CSR_HOLD:        hold = value & 32'hFF;
         CSR_PREROLL:     preroll = value & 32'hFF;
         default: ;
      endcase
   endtask

   task automatic set_regs(int unsigned g, int unsigned s, int unsigned a,
                           int unsigned r, int unsigned h, int unsigned p);
      drain();
      write_reg(CSR_GATE_THR, g);
      write_reg(CSR_SILENCE_THR, s);
      write_reg(CSR_ATTACK, a);
      write_reg(CSR_RELEASE, r);
      write_reg(CSR_HOLD, h);
      write_reg(CSR_PREROLL, p);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] make_sample(bit loud);
      logic signed [15:0] v;
      if (loud) begin
         v = 16'($urandom);
         return v >>> $urandom_range(0, 5);
      end
      return 16'($urandom_range(0, 60) - 30);
   endfunction

   function automatic int unsigned pick_thr();
      if ($urandom_range(0, 3) == 0)
         return 32767 * $urandom_range(0, 1);
      return $urandom_range(0, 1500);
   endfunction

   function automatic int unsigned pick_frames();
      if ($urandom_range(0, 5) == 0)
         return $urandom_range(0, 255);
      return $urandom_range(0, 3);
   endfunction

   // Loud frames lie in [loud_lo, loud_hi); a few reads are mixed into the loads.
   task automatic send_utterance(int unsigned len, int unsigned loud_lo,
                                 int unsigned loud_hi, int unsigned read_pct);
      int unsigned f;
      for (int unsigned i = 0; i < len; i++) begin
         f = i / FRAME;
         if ($urandom_range(0, 99) < read_pct)
            send_beat(CMD_READ, 16'($urandom), 1'b0, 16'($urandom_range(0, 200)));
         send_beat(CMD_LOAD, make_sample(f >= loud_lo && f < loud_hi), i == len - 1,
                   16'($urandom));
      end
   endtask

   task automatic read_burst(int count);
      logic [15:0] idx;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: idx = 16'($urandom);
            1: idx = 16'(cut_length);
            2: idx = 16'hFFFF;
            default: idx = (cut_length > 0) ? 16'($urandom_range(0, cut_length - 1)) : 16'd0;
         endcase
         send_beat(CMD_READ, 16'($urandom), 1'($urandom_range(0, 1)), idx);
      end
   endtask

   task automatic test_directed();
      send_beat(CMD_READ, 16'h0000, 1'b0, 16'h0000);
      send_beat(CMD_READ, 16'hFFFF, 1'b1, 16'hFFFF);
      send_beat(CMD_LOAD, 16'h7FFF, 1'b1, 16'hFFFF);
      read_burst(2);
      send_utterance(FRAME, 0, 1, 0);
      send_beat(CMD_READ, 16'h0000, 1'b0, 16'd159);
      send_beat(CMD_READ, 16'h0000, 1'b0, 16'd160);
      send_beat(CMD_LOAD, 16'h8000, 1'b0, 16'h0000);
      send_beat(CMD_LOAD, 16'h8000, 1'b1, 16'h0000);
      read_burst(3);
      set_regs(492, 655, 6554, 131, 1, 0);
      send_utterance(FRAME * 2 + 37, 1, 2, 0);
      read_burst(4);
   endtask

   task automatic test_register_extremes();
      set_regs(32767, 32767, 0, 65536, 0, 255);
      send_utterance(FRAME + 3, 0, 2, 5);
      read_burst(6);
      set_regs(0, 0, 65536, 0, 255, 0);
      send_utterance(FRAME + 90, 1, 2, 5);
      read_burst(6);
      set_regs(300, 700, 65536, 65536, 0, 0);
      send_utterance(FRAME + 20, 9, 9, 0);
      read_burst(6);
   endtask

   task automatic test_backpressure();
      set_regs(492, 655, 6554, 131, 1, 1);
      send_utterance(FRAME + 10, 0, 1, 0);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = 600;
      read_burst(40);
      drain();
   endtask

   task automatic test_random();
      int len, frames, lo;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 57; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 57; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         set_regs(pick_thr(), pick_thr(),
                  $urandom_range(0, 65536), $urandom_range(0, 65536),
                  pick_frames(), pick_frames());
         frames = $urandom_range(0, 1);
         len = frames * FRAME + $urandom_range(1, FRAME);
         lo = $urandom_range(0, frames);
         send_utterance(len, lo, lo + $urandom_range(0, 2), 2);
         read_burst($urandom_range(4, 12));
      end
   endtask

   initial begin
      int waited;
      gate_thr = GATE_THR_RESET;
      silence_thr = SILENCE_THR_RESET;
      attack = ATTACK_RESET;
      release_step = RELEASE_RESET;
      hold = HOLD_RESET;
      preroll = PREROLL_RESET;
      loaded_cnt = 0;
      cut_start = 0;
      cut_length = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random();
      req_tvalid <= 1'b0;
      waited = 0;
      while (trim_expected.size() != 0 && waited < 2000000) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && trim_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> frame_noise_gate_silence_trim_unit.f
hw/rtl/fnst_pkg.sv
hw/rtl/fnst_ram.sv
hw/rtl/fnst_datapath.sv
hw/rtl/fnst_ctrl.sv
hw/rtl/frame_noise_gate_silence_trim_unit.sv
test/frame_noise_gate_silence_trim_unit_test.sv
